// ===== hdl/spsm_pkg.sv =====
// shared types, field widths and codes of the slotted page space manager
`default_nettype none

package spsm_pkg;

    // default geometry of the page
    localparam int PAGE_BYTES_DEF = 8192;
    localparam int MAX_SLOTS_DEF  = 1024;

    // field widths of the request and result channels
    localparam int OPC_W    = 1;
    localparam int LEN_W    = 14;
    localparam int OFF_W    = 13;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 10;
    localparam int POS_W    = 13;
    localparam int COUNT_W  = 11;

    // page header layout
    localparam int WORD_BYTES   = 4;
    localparam int HEADER_WORDS = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD    = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED    = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_DELETED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_ZERO = 3'd1,
        IDX_LAST = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_UP   = 2'd1,
        WR_DOWN = 2'd2,
        WR_PUT  = 2'd3
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        t_idx_op idx_op;
        logic    free_upd;
        logic    take_gap;
        logic    take_bottom;
        logic    mark_del;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        logic    res_set;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_del;
        logic len_short;
        logic dir_full;
        logic count_zero;
        logic is_last;
        logic page_full;
        logic gap_fits;
        logic bottom_fits;
        logic pos_match;
        logic at_rank;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/spsm_req_if.sv =====
// request channel of the slotted page space manager
`default_nettype none

interface spsm_req_if import spsm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [LEN_W-1:0] record_length;
    logic [OFF_W-1:0] record_offset;

    modport source (output valid, output opcode, output record_length,
                    output record_offset, input ready);
    modport sink   (input valid, input opcode, input record_length,
                    input record_offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/spsm_rsp_if.sv =====
// result channel of the slotted page space manager
`default_nettype none

interface spsm_rsp_if import spsm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   slot_rank;
    logic [POS_W-1:0]    record_position;
    logic [COUNT_W-1:0]  record_count;

    modport source (output valid, output status, output slot_rank,
                    output record_position, output record_count, input ready);
    modport sink   (input valid, input status, input slot_rank,
                    input record_position, input record_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/spsm_ctrl.sv =====
// sequencing state machine of the slotted page space manager
`default_nettype none

module spsm_ctrl import spsm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    output logic  o_rsp_valid,
    input  logic  i_rsp_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_START   = 11'b000_0000_0010,
        S_FULL    = 11'b000_0000_0100,
        S_ASCAN   = 11'b000_0000_1000,
        S_BOTTOM  = 11'b000_0001_0000,
        S_SHUP    = 11'b000_0010_0000,
        S_PUT     = 11'b000_0100_0000,
        S_DSCAN   = 11'b000_1000_0000,
        S_SHDN    = 11'b001_0000_0000,
        S_DEL_END = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_START;
                end
            end
            S_START: begin
                if (i_stat.op_del) begin
                    if (i_stat.count_zero) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        n_state        = S_DONE;
                    end else begin
                        cmd.idx_op = IDX_ZERO;
                        n_state    = S_DSCAN;
                    end
                end else if (i_stat.len_short || i_stat.dir_full) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NO_ROOM;
                    n_state        = S_DONE;
                end else if (i_stat.count_zero) begin
                    n_state = S_BOTTOM;
                end else begin
                    cmd.idx_op = IDX_LAST;
                    n_state    = S_FULL;
                end
            end
            S_FULL: begin
                if (i_stat.page_full) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NO_ROOM;
                    n_state        = S_DONE;
                end else begin
                    cmd.idx_op = IDX_ZERO;
                    n_state    = S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (i_stat.gap_fits) begin
                    cmd.take_gap = 1'b1;
                    cmd.idx_op   = IDX_LAST;
                    n_state      = S_SHUP;
                end else begin
                    cmd.free_upd = 1'b1;
                    if (i_stat.is_last) begin
                        n_state = S_BOTTOM;
                    end else begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_BOTTOM: begin
                if (i_stat.bottom_fits) begin
                    cmd.take_bottom = 1'b1;
                    n_state         = S_PUT;
                end else begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NO_ROOM;
                    n_state        = S_DONE;
                end
            end
            S_SHUP: begin
                cmd.wr_op = WR_UP;
                if (i_stat.at_rank) begin
                    n_state = S_PUT;
                end else begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_PUT: begin
                cmd.wr_op      = WR_PUT;
                cmd.cnt_op     = CNT_INC;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_PLACED;
                n_state        = S_DONE;
            end
            S_DSCAN: begin
                if (i_stat.pos_match) begin
                    cmd.mark_del = 1'b1;
                    if (i_stat.is_last) begin
                        n_state = S_DEL_END;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        n_state    = S_SHDN;
                    end
                end else if (i_stat.is_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHDN: begin
                cmd.wr_op = WR_DOWN;
                if (i_stat.is_last) begin
                    n_state = S_DEL_END;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DEL_END: begin
                cmd.cnt_op     = CNT_DEC;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_DELETED;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // wait until the output register has been emptied
                if (!r_rsp_valid || i_rsp_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_rsp_valid = r_rsp_valid;

`ifndef NO_ASSERTIONS
    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_rsp_valid || i_rsp_ready))
        else $error("result loaded over a pending result");
`endif

endmodule

`default_nettype wire

// ===== hdl/spsm_dpath.sv =====
// slot directory memory, record count and scan arithmetic
`default_nettype none

module spsm_dpath import spsm_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OPC_W-1:0]    i_opcode,
    input  logic [LEN_W-1:0]    i_record_length,
    input  logic [OFF_W-1:0]    i_record_offset,
    output logic [STATUS_W-1:0] o_status,
    output logic [RANK_W-1:0]   o_slot_rank,
    output logic [POS_W-1:0]    o_record_position,
    output logic [COUNT_W-1:0]  o_record_count
);

    localparam int PW  = $clog2(PAGE_BYTES);
    localparam int IW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int LW  = LEN_W;
    localparam int EW  = PW + LW;
    localparam int MW  = (PW > LW) ? PW : LW;
    localparam int AW  = ((MW > CW + 2) ? MW : CW + 2) + 3;

    logic [EW-1:0]      mem [MAX_SLOTS];
    logic [EW-1:0]      r_rd_data;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx, n_idx;
    logic [OPC_W-1:0]   r_op;
    logic [LW-1:0]      r_len;
    logic [OFF_W-1:0]   r_off;
    logic [AW-1:0]      r_free_end;
    logic [IW-1:0]      r_rank;
    logic [PW-1:0]      r_pos;
    t_status            r_res_status;
    logic [STATUS_W-1:0] r_out_status;
    logic [RANK_W-1:0]  r_out_rank;
    logic [POS_W-1:0]   r_out_pos;
    logic [COUNT_W-1:0] r_out_count;

    logic [PW-1:0]      rd_pos;
    logic [LW-1:0]      rd_len;
    logic [IW-1:0]      last_idx;
    logic [AW-1:0]      ext_pos, ext_len, rec_end, hdr_now, hdr_next;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;

    assign rd_pos   = r_rd_data[EW-1:LW];
    assign rd_len   = r_rd_data[LW-1:0];
    assign last_idx = IW'(r_count - CW'(1));
    assign ext_pos  = AW'(rd_pos);
    assign ext_len  = AW'(r_len);
    assign rec_end  = ext_pos + AW'(rd_len);
    assign hdr_now  = (AW'(r_count) + AW'(HEADER_WORDS)) * AW'(WORD_BYTES);
    assign hdr_next = hdr_now + AW'(WORD_BYTES);

    // status toward the controller
    always_comb begin
        o_stat.op_del      = (r_op == OP_DELETE);
        o_stat.len_short   = (r_len < LW'(WORD_BYTES));
        o_stat.dir_full    = (r_count >= CW'(MAX_SLOTS));
        o_stat.count_zero  = (r_count == '0);
        o_stat.is_last     = ((CW'(r_idx) + CW'(1)) == r_count);
        o_stat.page_full   = (ext_pos == hdr_now);
        o_stat.gap_fits    = ($signed(r_free_end - rec_end) >= $signed(ext_len));
        o_stat.bottom_fits = ($signed(r_free_end - hdr_next) >= $signed(ext_len));
        o_stat.pos_match   = (ext_pos == AW'(r_off));
        o_stat.at_rank     = (r_idx == r_rank);
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_HOLD: n_idx = r_idx;
            IDX_ZERO: n_idx = '0;
            IDX_LAST: n_idx = last_idx;
            IDX_INC:  n_idx = r_idx + IW'(1);
            IDX_DEC:  n_idx = r_idx - IW'(1);
            default:  n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_HOLD: n_count = r_count;
            CNT_INC:  n_count = r_count + CW'(1);
            CNT_DEC:  n_count = r_count - CW'(1);
            default:  n_count = r_count;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = r_rd_data;
        case (i_cmd.wr_op)
            WR_NONE: wr_en   = 1'b0;
            WR_UP:   wr_addr = r_idx + IW'(1);
            WR_DOWN: wr_addr = r_idx - IW'(1);
            WR_PUT: begin
                wr_addr = r_rank;
                wr_data = {r_pos, r_len};
            end
            default: wr_en = 1'b0;
        endcase
    end

    // one write and one registered read per cycle, read follows the next index
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_len      <= i_record_length;
            r_off      <= i_record_offset;
            r_free_end <= AW'(PAGE_BYTES);
        end
        if (i_cmd.free_upd) begin
            r_free_end <= ext_pos;
        end
        if (i_cmd.take_gap) begin
            r_rank <= r_idx;
            r_pos  <= PW'(rec_end);
        end
        if (i_cmd.take_bottom) begin
            r_rank <= IW'(r_count);
            r_pos  <= PW'(r_free_end - ext_len);
        end
        if (i_cmd.mark_del) begin
            r_rank <= r_idx;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_count  <= COUNT_W'(r_count);
            case (r_res_status)
                ST_PLACED: begin
                    r_out_rank <= RANK_W'(r_rank);
                    r_out_pos  <= POS_W'(r_pos);
                end
                ST_DELETED: begin
                    r_out_rank <= RANK_W'(r_rank);
                    r_out_pos  <= POS_W'(r_off);
                end
                default: begin
                    r_out_rank <= '0;
                    r_out_pos  <= '0;
                end
            endcase
        end
    end

    assign o_status          = r_out_status;
    assign o_slot_rank       = r_out_rank;
    assign o_record_position = r_out_pos;
    assign o_record_count    = r_out_count;

`ifndef NO_ASSERTIONS
    // the directory never holds more slots than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SLOTS))
        else $error("record count beyond directory size");

    // an insert grows the directory by exactly one slot
    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_INC) |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("record count did not grow by one");

    // shifting up only moves slots that exist
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == WR_UP) |-> (CW'(r_idx) < r_count))
        else $error("shift up outside the directory");
`endif

endmodule

`default_nettype wire

// ===== hdl/slotted_page_space_manager_core.sv =====
// top level of the slotted page space manager
`default_nettype none

// Keeps the slot directory of one page: add places a record in the first
// free gap found from the page end, or below the lowest record, and delete
// drops the slot of a given record position. The directory lives in a
// single-port-write, single-read memory that is walked one slot per clock,
// so the rate follows the record count n. A placed add scans down to the
// rank, then moves the later slots up; a delete searches, then moves the
// later slots down. The next request is taken in the cycle after the result
// is loaded, and a result held up by the receiver stalls the block.
// The directory memory needs no clearing after reset: only slots below the
// record count are ever read. A new request is taken while the last result
// still waits in the output register.
module slotted_page_space_manager_core import spsm_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spsm_req_if.sink  i_req,
    spsm_rsp_if.source o_rsp
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // state machine: accepts requests, steps the scan and shift loops
    spsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: directory memory, record count, fit arithmetic, result register
    spsm_dpath #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (i_req.opcode),
        .i_record_length   (i_req.record_length),
        .i_record_offset   (i_req.record_offset),
        .o_status          (o_rsp.status),
        .o_slot_rank       (o_rsp.slot_rank),
        .o_record_position (o_rsp.record_position),
        .o_record_count    (o_rsp.record_count)
    );

endmodule

`default_nettype wire

// ===== tb/spsm_page_checker.sv =====
// result checker of the slotted page space manager: predicts each result and compares it
`default_nettype none

module spsm_page_checker import spsm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    spsm_req_if  i_req,
    spsm_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int PAGE_END   = PAGE_BYTES_DEF;
    localparam int SLOT_CAP   = MAX_SLOTS_DEF;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        t_status            status;
        logic [RANK_W-1:0]  rank;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
    } t_page_result;

    // own copy of the slot directory, descending record position by rank
    logic [POS_W-1:0] dir_pos [SLOT_CAP];
    logic [LEN_W-1:0] dir_len [SLOT_CAP];
    int               dir_count = 0;

    t_page_result     due_results [$];
    int               fails = 0;
    int               checked = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(string field, int got_v, int want_v);
        fails++;
        if (fails <= MAX_PRINTS)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, checked, field, got_v, want_v);
    endtask

    // applies one request to the directory and returns the result it causes
    function automatic t_page_result directory_step(t_opcode op, int len, int off);
        t_page_result res;
        int           free_end;
        int           rec_end;
        int           place_at;
        int           hit;
        res      = '0;
        res.status = ST_NO_ROOM;
        free_end = PAGE_END;
        place_at = 0;
        hit      = -1;
        if (op == OP_DELETE) begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < dir_count && hit < 0; i++)
                if (int'(dir_pos[i]) == off) hit = i;
            if (hit >= 0) begin
                for (int j = hit; j < dir_count - 1; j++) begin
                    dir_pos[j] = dir_pos[j + 1];
                    dir_len[j] = dir_len[j + 1];
                end
                dir_count--;
                res.status = ST_DELETED;
                res.rank   = RANK_W'(hit);
                res.pos    = POS_W'(off);
            end
        end else if (len >= WORD_BYTES && dir_count < SLOT_CAP &&
                     !(dir_count > 0 && int'(dir_pos[dir_count - 1]) ==
                       (HEADER_WORDS + dir_count) * WORD_BYTES)) begin
            // first fit from the page end
            for (int i = 0; i < dir_count && hit < 0; i++) begin
                rec_end = int'(dir_pos[i]) + int'(dir_len[i]);
                if (free_end - rec_end >= len) begin
                    hit      = i;
                    place_at = rec_end;
                end else begin
                    free_end = dir_pos[i];
                end
            end
            // below the lowest record, keeping room for the new slot word
            if (hit < 0 && free_end - (HEADER_WORDS + dir_count + 1) * WORD_BYTES >= len) begin
                hit      = dir_count;
                place_at = free_end - len;
            end
            if (hit >= 0) begin
                for (int j = dir_count; j > hit; j--) begin
                    dir_pos[j] = dir_pos[j - 1];
                    dir_len[j] = dir_len[j - 1];
                end
                dir_pos[hit] = POS_W'(place_at);
                dir_len[hit] = LEN_W'(len);
                dir_count++;
                res.status = ST_PLACED;
                res.rank   = RANK_W'(hit);
                res.pos    = POS_W'(place_at);
            end
        end
        res.count = COUNT_W'(dir_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result, status", int'(i_rsp.status), -1);
                end else begin
                    want = due_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", int'(i_rsp.status), int'(want.status));
                    if (i_rsp.slot_rank !== want.rank)
                        report_mismatch("slot_rank", int'(i_rsp.slot_rank), int'(want.rank));
                    if (i_rsp.record_position !== want.pos)
                        report_mismatch("record_position", int'(i_rsp.record_position),
                                        int'(want.pos));
                    if (i_rsp.record_count !== want.count)
                        report_mismatch("record_count", int'(i_rsp.record_count),
                                        int'(want.count));
                end
            end
            if (i_req.valid && i_req.ready)
                due_results.insert(due_results.size(),
                                   directory_step(t_opcode'(i_req.opcode),
                                                  int'(i_req.record_length),
                                                  int'(i_req.record_offset)));
        end
        o_pending <= due_results.size();
    end

endmodule

`default_nettype wire

// ===== tb/slotted_page_space_manager_core_tb.sv =====
// stimulus and verdict for the slotted page space manager
`default_nettype none

module slotted_page_space_manager_core_tb;
    import spsm_pkg::*;

    localparam int PAGE_END     = PAGE_BYTES_DEF;
    localparam int CLK_PERIOD   = 8;
    localparam int FILL_RECORDS = 230;   // a few more than a page of 32-byte records holds
    localparam int FILL_LEN     = 32;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 250;   // tail of the run with no idling at all
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 300;
    localparam int TIGHT_EVERY  = 50;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    // idling on both sides while set; cleared for the last stretch
    bit   idling_on = 1'b1;
    // one-shot request for the receiver to hold off for a long stretch
    bit   hold_off_go = 1'b0;

    // shadow of the page as the results report it, used to aim requests
    int   sent_len [$];
    int   live_pos [$];
    int   len_at [PAGE_END];

    spsm_req_if req_ch ();
    spsm_rsp_if rsp_ch ();

    slotted_page_space_manager_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    spsm_page_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(CLK_PERIOD * 3_000_000);
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus the one long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_go) begin
                // block fills up and has to push back on the request side
                hold_off_go = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // keep the shadow page in step with the results that come back
    always @(posedge clk) begin
        int len;
        int pos;
        if (rst_n && rsp_ch.valid && rsp_ch.ready && sent_len.size() > 0) begin
            len = sent_len.pop_front();
            pos = int'(rsp_ch.record_position);
            if (t_status'(rsp_ch.status) == ST_PLACED) begin
                live_pos.insert(live_pos.size(), pos);
                len_at[pos] = len;
            end else if (t_status'(rsp_ch.status) == ST_DELETED) begin
                len_at[pos] = 0;
                for (int i = 0; i < live_pos.size(); i++)
                    if (live_pos[i] == pos) begin
                        live_pos.delete(i);
                        break;
                    end
            end
        end
    end

    // offers one request, maybe after an idle burst, and returns at its accepting edge;
    // valid stays high so back-to-back requests need no extra step
    task automatic send_request(t_opcode op, int len, int off);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            req_ch.valid         <= 1'b0;
            req_ch.opcode        <= OPC_W'($urandom);
            req_ch.record_length <= LEN_W'($urandom);
            req_ch.record_offset <= OFF_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.record_length <= LEN_W'(len);
        req_ch.record_offset <= OFF_W'(off);
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_len.insert(sent_len.size(), len & 16'h3fff);
    endtask

    // sender pauses until every outstanding result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // length that exactly fills a free gap, or the space left at the bottom of the page
    function automatic int tight_length(bit use_gap);
        int fe;
        int gap;
        int n;
        int gaps [$];
        fe = PAGE_END;
        n  = 0;
        for (int p = PAGE_END - 1; p >= 0; p--)
            if (len_at[p] != 0) begin
                gap = fe - (p + len_at[p]);
                if (gap >= WORD_BYTES) gaps.insert(gaps.size(), gap);
                fe = p;
                n++;
            end
        if (use_gap && gaps.size() > 0)
            return gaps[$urandom_range(0, gaps.size() - 1)];
        return fe - (HEADER_WORDS + n + 1) * WORD_BYTES;
    endfunction

    // add aimed at a boundary of the fit checks, one byte off either way or exact
    task automatic fill_tight(bit use_gap, int delta);
        int len;
        wait_drained();
        len = tight_length(use_gap) + delta;
        if (len < 0) len = 0;
        send_request(OP_ADD, len, $urandom);
    endtask

    // deletes the given share of the live records in random order
    task automatic drop_records(bit all_of_them);
        int doomed [$];
        int idx;
        int n;
        wait_drained();
        doomed = live_pos;
        n = all_of_them ? doomed.size() : doomed.size() / 2;
        repeat (n) begin
            idx = $urandom_range(0, doomed.size() - 1);
            send_request(OP_DELETE, $urandom, doomed[idx]);
            doomed.delete(idx);
        end
    endtask

    // random request shaped to keep the page busy but not overfull
    task automatic random_request();
        int n;
        int del_pct;
        int roll;
        int len;
        n = live_pos.size();
        del_pct = (n < 8) ? 20 : (n < 24) ? 45 : 70;
        if ($urandom_range(0, 99) < del_pct) begin
            if (n > 0 && $urandom_range(0, 9) != 0)
                send_request(OP_DELETE, $urandom, live_pos[$urandom_range(0, n - 1)]);
            else
                send_request(OP_DELETE, $urandom, $urandom_range(0, PAGE_END - 1));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      len = $urandom_range(WORD_BYTES, 600);
            else if (roll < 85) len = $urandom_range(600, 3000);
            else if (roll < 95) len = $urandom_range(0, 16383);
            else                len = $urandom_range(0, WORD_BYTES - 1);
            send_request(OP_ADD, len, $urandom);
        end
    endtask

    initial begin
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_ADD;
        req_ch.record_length <= '0;
        req_ch.record_offset <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty page, refused lengths, fits, gaps and the full page
        send_request(OP_DELETE, 0, 0);           // delete on an empty page
        send_request(OP_ADD, 0, 0);              // short records
        send_request(OP_ADD, WORD_BYTES - 1, 0);
        send_request(OP_ADD, 16383, 8191);       // oversized, all length bits set
        send_request(OP_ADD, PAGE_END, 0);
        send_request(OP_ADD, WORD_BYTES, 0);     // smallest record, at the page end
        send_request(OP_ADD, 100, 0);
        send_request(OP_ADD, 200, 0);
        send_request(OP_DELETE, 0, PAGE_END - WORD_BYTES - 100);  // middle slot goes
        send_request(OP_DELETE, 0, 4321);        // offset that holds no record
        send_request(OP_ADD, 101, 0);            // one too big for the gap, goes below
        send_request(OP_ADD, 100, 0);            // exact gap fit
        send_request(OP_DELETE, 0, PAGE_END - WORD_BYTES);        // top slot, leaves a gap
        fill_tight(1'b0, 1);                     // bottom misses by the slot word reserve
        fill_tight(1'b0, 0);                     // lowest record now touches the header
        send_request(OP_ADD, WORD_BYTES, 0);     // refused although a gap is free above
        drop_records(1'b1);

        // one deep directory: fill, thin out, refill the holes, empty again
        repeat (FILL_RECORDS) send_request(OP_ADD, FILL_LEN, $urandom);
        fill_tight(1'b0, 0);
        send_request(OP_ADD, WORD_BYTES, $urandom);
        drop_records(1'b0);
        repeat (60) send_request(OP_ADD, $urandom_range(WORD_BYTES, 80), $urandom);
        drop_records(1'b1);

        // random traffic with periodic boundary-sized adds after a full drain
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
            if (k == HOLD_AT) hold_off_go = 1'b1;
            if (k % TIGHT_EVERY == TIGHT_EVERY - 1)
                fill_tight($urandom_range(0, 1), int'($urandom_range(0, 2)) - 1);
            else
                random_request();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
